>>> hdl/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared constants, types and the digit-to-character map for the
// integer-to-radix-digits converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

  // Digit stack depth; legal range 8..64.
  localparam int DIGIT_DEPTH   = 64;
  localparam int CNT_W         = $clog2(DIGIT_DEPTH + 1);
  localparam int ADDR_W        = $clog2(DIGIT_DEPTH);

  localparam int VAL_W         = 64;
  localparam int BASE_W        = 6;
  localparam int CHAR_W        = 7;
  localparam int DIG_W         = 6;

  // Divider retires this many quotient bits per cycle.
  localparam int BITS_PER_STEP = 8;
  localparam int STEPS         = VAL_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(STEPS);

  localparam logic [BASE_W-1:0] RADIX_MIN  = BASE_W'(2);
  localparam logic [BASE_W-1:0] RADIX_MAX  = BASE_W'(36);
  localparam logic [DIG_W-1:0]  DIGIT_MAX  = DIG_W'(35);
  localparam logic [DIG_W-1:0]  DEC_DIGITS = DIG_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2D);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0] CHAR_ERR   = CHAR_W'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_PUSH,
    ST_SIGN,
    ST_READ,
    ST_EMIT,
    ST_ERR
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture a new request
    logic div_step;   // retire one group of quotient bits
    logic push;       // push remainder, bump digit count
    logic rd;         // read top of digit stack
    logic out_sign;   // load '-' into the output register
    logic out_digit;  // load a digit character, pop the stack
    logic out_err;    // load the error result, clear state
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic bad_in;     // radix out of range or most negative value
    logic neg;
    logic step_last;  // final divider step of this digit
    logic quot_zero;
    logic cnt_full;   // no room for another digit
    logic cnt_last;   // one digit left on the stack
    logic out_free;   // output register can take a new result
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [DIG_W-1:0] dc;
    dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    if (dc < DEC_DIGITS) begin
      return CHAR_ZERO + {1'b0, dc};
    end
    return CHAR_A + {1'b0, dc} - {1'b0, DEC_DIGITS};
  endfunction

endpackage

>>> hdl/itrd_dp.sv
// ----------------------------------------------------------------------------
// itrd_dp
// Datapath: request registers, shared radix divider, digit stack and the
// output register.
// ----------------------------------------------------------------------------
module itrd_dp import itrd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic signed [VAL_W-1:0]  in_number_in,
  input  logic [BASE_W-1:0]        in_base,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CHAR_W-1:0]        out_char_code,
  output logic                     out_error,
  output logic                     out_last_char
);

  logic [VAL_W-1:0]         work_r, work_nxt;
  logic [BASE_W-1:0]        radix_r;
  logic                     neg_r;
  logic                     bad_r;
  logic [DIG_W-1:0]         rem_r, rem_nxt;
  logic [STEP_W-1:0]        step_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [DIG_W-1:0]         rd_data_r;
  logic                     out_valid_r;
  logic [CHAR_W-1:0]        out_char_r;
  logic                     out_error_r;
  logic                     out_last_r;
  logic [DIG_W-1:0]         stack_mem [DIGIT_DEPTH];

  logic [VAL_W-1:0]         raw;
  logic [VAL_W-1:0]         mag;
  logic                     in_neg;
  logic                     in_bad;
  logic [DIG_W:0]           rem_v;
  logic [BITS_PER_STEP-1:0] q_bits;
  logic [CNT_W-1:0]         cnt_dec;
  logic                     out_load;

  assign raw    = in_number_in;
  assign in_neg = raw[VAL_W-1];
  assign mag    = in_neg ? (VAL_W'(0) - raw) : raw;
  assign in_bad = (in_base < RADIX_MIN) || (in_base > RADIX_MAX) ||
                  (raw == {1'b1, {(VAL_W-1){1'b0}}});

  // Restoring division, MSB first, BITS_PER_STEP bits per cycle.
  always_comb begin
    rem_v = {1'b0, rem_r};
    q_bits = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      rem_v = {rem_v[DIG_W-1:0], work_r[VAL_W-1-i]};
      if (rem_v >= {1'b0, radix_r}) begin
        rem_v = rem_v - {1'b0, radix_r};
        q_bits[BITS_PER_STEP-1-i] = 1'b1;
      end
    end
    work_nxt = {work_r[VAL_W-BITS_PER_STEP-1:0], q_bits};
    rem_nxt  = rem_v[DIG_W-1:0];
  end

  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign out_load = cmd.out_sign || cmd.out_digit || cmd.out_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r <= '0;
      cnt_r  <= '0;
      step_r <= '0;
      rem_r  <= '0;
    end else begin
      if (cmd.load) begin
        work_r <= mag;
        cnt_r  <= '0;
        step_r <= '0;
        rem_r  <= '0;
      end else if (cmd.div_step) begin
        work_r <= work_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r + STEP_W'(1);
      end else if (cmd.push) begin
        cnt_r <= cnt_r + CNT_W'(1);
        rem_r <= '0;
      end else if (cmd.out_digit) begin
        cnt_r <= cnt_dec;
      end else if (cmd.out_err) begin
        cnt_r  <= '0;
        work_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      radix_r <= in_base;
      neg_r   <= in_neg;
      bad_r   <= in_bad;
    end
  end

  // Digit stack.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[cnt_r[ADDR_W-1:0]] <= rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= stack_mem[cnt_dec[ADDR_W-1:0]];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_err) begin
      out_char_r  <= CHAR_ERR;
      out_error_r <= 1'b1;
      out_last_r  <= 1'b1;
    end else if (cmd.out_sign) begin
      out_char_r  <= CHAR_MINUS;
      out_error_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (cmd.out_digit) begin
      out_char_r  <= digit_char(rd_data_r);
      out_error_r <= 1'b0;
      out_last_r  <= (cnt_r == CNT_W'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_error     = out_error_r;
  assign out_last_char = out_last_r;

  always_comb begin
    sts.bad_in    = bad_r;
    sts.neg       = neg_r;
    sts.step_last = (step_r == STEP_W'(STEPS - 1));
    sts.quot_zero = (work_r == '0);
    sts.cnt_full  = ((cnt_r + CNT_W'(neg_r)) >= CNT_W'(DIGIT_DEPTH));
    sts.cnt_last  = (cnt_r == CNT_W'(1));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (cnt_r < CNT_W'(DIGIT_DEPTH)))
    else $error("digit pushed onto a full stack");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.out_digit) |-> (cnt_r != '0))
    else $error("digit popped from an empty stack");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (rem_r == '0) && (step_r == '0) && (cnt_r == '0))
    else $error("divider not cleared on a new request");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_err |=> out_valid && out_error && out_last_char && (out_char_code == CHAR_ERR))
    else $error("error result malformed");

endmodule

>>> hdl/itrd_ctrl.sv
// ----------------------------------------------------------------------------
// itrd_ctrl
// Controller: sequences checking, digit division, stack pushes and the
// most-significant-first emission of characters.
// ----------------------------------------------------------------------------
module itrd_ctrl import itrd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Reject bad requests, and stop when another digit would overflow.
        if (sts.bad_in || sts.cnt_full) begin
          state_nxt = ST_ERR;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        if (!sts.quot_zero) begin
          state_nxt = ST_CHECK;
        end else if (sts.neg) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.out_sign = 1'b1;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_digit = 1'b1;
          state_nxt     = sts.cnt_last ? ST_IDLE : ST_READ;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.out_err = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_one_out_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.out_sign, cmd.out_digit, cmd.out_err}))
    else $error("more than one output load in a cycle");

  a_push_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> $past(cmd.div_step))
    else $error("push without a finished division");

  a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_digit |-> (state_r == ST_EMIT) && !in_stall == 1'b0)
    else $error("digit emitted outside the emit state");

endmodule

>>> hdl/integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a signed 64-bit integer to ASCII text in radix 2..36, one
// character per output request, most significant digit first; a radix
// outside that range or the most negative value gives an error result.
// Each digit takes a check, the divider steps at 8 quotient bits per cycle
// and a push; each character then takes a stack read and an output load,
// and a sign character goes out first. An error result is loaded from the
// error state after the check, once the output register is free.
// One request is in work at a time; the next one is taken once the final
// character sits in the output register. Reset (synchronous, rst_n low)
// returns the controller to idle, empties the output register and clears
// the digit count; the digit stack itself is not cleared.
// ----------------------------------------------------------------------------
module integer_to_radix_digits import itrd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [VAL_W-1:0]  in_number_in,
  input  logic [BASE_W-1:0]        in_base,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CHAR_W-1:0]        out_char_code,
  output logic                     out_error,
  output logic                     out_last_char
);

  // Commands from the controller, status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  // Controller: idle, check, divide, push, then sign and pop/emit loop, or error.
  itrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: magnitude register, shared divider, digit stack, output reg.
  itrd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_number_in  (in_number_in),
    .in_base       (in_base),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_error     (out_error),
    .out_last_char (out_last_char)
  );

  // Hold requests while a conversion is in flight.
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> in_stall)
    else $error("new request taken during a conversion");

  // A result loaded while the previous one is still stalled would be lost.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_sign || cmd.out_digit || cmd.out_err) |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  // The final character of a conversion frees the input side next cycle.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_err || (cmd.out_digit && sts.cnt_last)) |=> !in_stall)
    else $error("controller did not return to idle after the last character");

endmodule
